FILE: src/mhj_pkg.sv
// Shared types and constants for the multibit Huffman jump decoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package mhj_pkg;

    localparam int JUMP_BITS   = 8;
    localparam int TABLE_COUNT = 256;
    localparam int MAX_SYMBOLS = 7;

    localparam int KIND_W       = 2;
    localparam int ADDR_FIELD_W = 16;
    localparam int TABLE_W      = 8;
    localparam int COUNT_W      = 3;
    localparam int SYM_W        = 8;
    localparam int SLOTS        = 7;
    localparam int SYMBOLS_W    = SLOTS * SYM_W;
    localparam int CHUNK_W      = 8;

    localparam int STORE_DEPTH = TABLE_COUNT << JUMP_BITS;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int LOOKUP_W    = TABLE_W + JUMP_BITS;

    localparam logic [31:0]        STORE_DEPTH_L = 32'(STORE_DEPTH);
    localparam logic [COUNT_W-1:0] MAX_COUNT     = COUNT_W'(MAX_SYMBOLS);

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD    = 2'd0,
        KIND_CHUNK   = 2'd1,
        KIND_RESTART = 2'd2
    } kind_t;

    typedef logic [SLOTS-1:0][SYM_W-1:0] symbols_t;

    typedef struct packed {
        symbols_t             symbols;
        logic [COUNT_W-1:0]   count;
        logic [TABLE_W-1:0]   next_table;
    } entry_t;

endpackage

`default_nettype wire

FILE: src/mhj_store.sv
// Jump-table store: one synchronous memory holding every table entry.
// Uses entry_t and the store geometry from mhj_pkg.
`default_nettype none

module mhj_store
    import mhj_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                wr_en,
    input  wire logic [STORE_AW-1:0] wr_addr,
    input  wire entry_t              wr_data,
    input  wire logic                rd_en,
    input  wire logic [STORE_AW-1:0] rd_addr,
    output entry_t                   rd_data
);

    entry_t mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: src/mhj_emit.sv
// Symbol emitter: walks the symbols of one looked-up entry and drives the
// output register, one word per cycle unless stalled. Uses entry_t from mhj_pkg.
`default_nettype none

module mhj_emit
    import mhj_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire entry_t            entry,
    input  wire logic              out_stall,
    output logic                   idle_next,
    output logic                   out_valid,
    output logic [SYM_W-1:0]       symbol,
    output logic                   last
);

    symbols_t           syms_reg;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] idx_reg;
    logic               out_valid_reg;
    logic [SYM_W-1:0]   symbol_reg;
    logic               last_reg;

    symbols_t           src_syms;
    logic [COUNT_W-1:0] src_cnt;
    logic [COUNT_W-1:0] src_idx;
    logic [COUNT_W-1:0] idx_inc;
    logic [COUNT_W-1:0] idx_next;
    logic               out_ready;
    logic               push;

    always_comb
    begin
        if (load)
        begin
            src_syms = entry.symbols;
            src_cnt  = (entry.count > MAX_COUNT) ? MAX_COUNT : entry.count;
            src_idx  = '0;
        end
        else
        begin
            src_syms = syms_reg;
            src_cnt  = cnt_reg;
            src_idx  = idx_reg;
        end
        out_ready = !out_valid_reg || !out_stall;
        push      = (src_idx != src_cnt) && out_ready;
        idx_inc   = src_idx + COUNT_W'(1);
        idx_next  = push ? idx_inc : src_idx;
        idle_next = (idx_next == src_cnt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= src_cnt;
            idx_reg <= idx_next;
            if (out_ready)
            begin
                out_valid_reg <= push;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        syms_reg <= src_syms;
        if (push)
        begin
            symbol_reg <= src_syms[src_idx];
            last_reg   <= (idx_inc == src_cnt);
        end
    end

    assign out_valid = out_valid_reg;
    assign symbol    = symbol_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

FILE: src/multibit_huffman_jump_decoder_core.sv
// Top level of the multibit Huffman jump decoder: input handshake, table
// tracking and lookup. Instantiates mhj_store and mhj_emit; uses mhj_pkg.
`default_nettype none

// Load and restart words are taken every cycle while no chunk waits. A chunk
// word's entry is read from the memory, and its symbols then leave at one
// word per cycle unless the output stalls; the next chunk is taken in the
// cycle in which the emitter hands out the previous entry's final symbol,
// or has none to hand out. The table chosen by a chunk is forwarded from
// the memory read data straight into the next lookup address. Table entries
// are undefined until loaded and are not cleared by reset.
module multibit_huffman_jump_decoder_core
    import mhj_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [KIND_W-1:0]       kind,
    input  wire logic [ADDR_FIELD_W-1:0] entry_addr,
    input  wire logic [TABLE_W-1:0]      entry_next_table,
    input  wire logic [COUNT_W-1:0]      entry_count,
    input  wire logic [SYMBOLS_W-1:0]    entry_symbols,
    input  wire logic [CHUNK_W-1:0]      chunk,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [SYM_W-1:0]             symbol,
    output logic                         last
);

    logic [TABLE_W-1:0]  table_reg;
    logic [TABLE_W-1:0]  table_next;
    logic                pend_reg;
    logic                pend_next;

    entry_t              rd_data;
    entry_t              wr_data;
    logic [TABLE_W-1:0]  cur_table;
    logic [LOOKUP_W-1:0] lookup;
    logic                lookup_ok;
    logic                load_ok;
    logic                is_load;
    logic                is_chunk;
    logic                is_restart;
    logic                accept;
    logic                idle_next;
    logic                wr_en;
    logic                rd_en;

    always_comb
    begin
        is_load    = (kind == KIND_LOAD);
        is_chunk   = (kind == KIND_CHUNK);
        is_restart = (kind == KIND_RESTART);
        cur_table  = pend_reg ? rd_data.next_table : table_reg;
        lookup     = {cur_table, JUMP_BITS'(chunk)};
        lookup_ok  = 32'(lookup) < STORE_DEPTH_L;
        load_ok    = 32'(entry_addr) < STORE_DEPTH_L;
        in_stall   = is_chunk && !idle_next;
        accept     = in_valid && !in_stall;
        wr_en      = accept && is_load && load_ok;
        rd_en      = accept && is_chunk && lookup_ok;
        pend_next  = rd_en;
        table_next = cur_table;
        if (accept && (is_restart || (is_chunk && !lookup_ok)))
        begin
            table_next = '0;
        end
        wr_data.symbols    = symbols_t'(entry_symbols);
        wr_data.count      = entry_count;
        wr_data.next_table = entry_next_table;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            table_reg <= table_next;
            pend_reg  <= pend_next;
        end
    end

    mhj_store u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (STORE_AW'(entry_addr)),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (STORE_AW'(lookup)),
        .rd_data (rd_data)
    );

    mhj_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (pend_reg),
        .entry     (rd_data),
        .out_stall (out_stall),
        .idle_next (idle_next),
        .out_valid (out_valid),
        .symbol    (symbol),
        .last      (last)
    );

endmodule

`default_nettype wire

FILE: tb/multibit_huffman_jump_decoder_core_test.sv
// Self-checking testbench for multibit_huffman_jump_decoder_core: directed table
// then random words of every kind, checked against typed or predicted symbols.
// Depends on mhj_pkg and the decoder RTL only.
module multibit_huffman_jump_decoder_core_test
    import mhj_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;
    localparam int RANDOM_WORDS = 88;
    localparam int DIRECTED_ROWS = 22;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [3:0][TABLE_W-1:0] HOT_TABLES = {8'hFF, 8'hA5, 8'h3C, 8'h00};

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic [ADDR_FIELD_W-1:0] addr;
        logic [TABLE_W-1:0]      next_tbl;
        logic [COUNT_W-1:0]      count;
        logic [SYMBOLS_W-1:0]    syms;
        logic [CHUNK_W-1:0]      chk;
        int                      typed_n;
        logic [SYMBOLS_W-1:0]    typed_syms;
    } stim_row_t;

    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic             last;
    } sym_out_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [KIND_W-1:0]       kind = '0;
    logic [ADDR_FIELD_W-1:0] entry_addr = '0;
    logic [TABLE_W-1:0]      entry_next_table = '0;
    logic [COUNT_W-1:0]      entry_count = '0;
    logic [SYMBOLS_W-1:0]    entry_symbols = '0;
    logic [CHUNK_W-1:0]      chunk = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [SYM_W-1:0]        symbol;
    logic                    last;

    entry_t             jump_entries [int unsigned];
    logic [TABLE_W-1:0] table_sel = '0;
    sym_out_t           predicted [$];
    sym_out_t           pending_symbols [$];
    stim_row_t          directed [DIRECTED_ROWS];

    bit          src_idle = 1'b1;
    bit          sink_idle = 1'b1;
    int unsigned stall_left = 0;
    int unsigned stall_draw;
    int unsigned cycle_count = 0;
    int          mismatches = 0;
    int          words_sent = 0;
    int          n_loads = 0;
    int          n_chunks = 0;
    int          n_restarts = 0;
    int          n_ignored = 0;
    int          symbols_checked = 0;
    sym_out_t    exp_out;

    multibit_huffman_jump_decoder_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .kind             (kind),
        .entry_addr       (entry_addr),
        .entry_next_table (entry_next_table),
        .entry_count      (entry_count),
        .entry_symbols    (entry_symbols),
        .chunk            (chunk),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .symbol           (symbol),
        .last             (last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d symbols still expected",
                     $time, cycle_count, pending_symbols.size());
            $display("multibit_huffman_jump_decoder_core verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (pending_symbols.size() == 0)
            begin
                $display("%0t: symbol with nothing expected: expected none, actual %h last %b",
                         $time, symbol, last);
                mismatches++;
            end
            else
            begin
                exp_out = pending_symbols.pop_front();
                if (symbol !== exp_out.sym)
                begin
                    $display("%0t: symbol mismatch: expected %h, actual %h",
                             $time, exp_out.sym, symbol);
                    mismatches++;
                end
                if (last !== exp_out.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, exp_out.last, last);
                    mismatches++;
                end
            end
            symbols_checked++;
            stall_draw = sink_idle ? $urandom_range(0, 6) : 0;
            stall_left <= stall_draw;
            out_stall <= (stall_draw != 0);
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall <= (stall_left > 1);
        end
    end

    function automatic void decode_word(input stim_row_t w);
        int unsigned lookup;
        int unsigned n;
        entry_t e;
        predicted.delete();
        case (w.kind)
            KIND_LOAD:
            begin
                if (int'(w.addr) < STORE_DEPTH)
                begin
                    e.symbols = w.syms;
                    e.count = w.count;
                    e.next_table = w.next_tbl;
                    jump_entries[w.addr] = e;
                end
            end
            KIND_CHUNK:
            begin
                lookup = {table_sel, w.chk[JUMP_BITS-1:0]};
                if (lookup < STORE_DEPTH)
                begin
                    e = jump_entries.exists(lookup) ? jump_entries[lookup] : '0;
                    n = (e.count > MAX_COUNT) ? MAX_COUNT : e.count;
                    for (int k = 0; k < n; k++)
                        predicted.push_back({e.symbols[k], 1'(k == n - 1)});
                    table_sel = e.next_table;
                end
                else
                    table_sel = '0;
            end
            KIND_RESTART:
                table_sel = '0;
            default:
                ;
        endcase
    endfunction

    task automatic send_word(input stim_row_t w);
        int unsigned gap;
        if (words_sent % 16 == 0)
        begin
            src_idle = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
        end
        gap = src_idle ? $urandom_range(0, 6) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= w.kind;
        entry_addr <= w.addr;
        entry_next_table <= w.next_tbl;
        entry_count <= w.count;
        entry_symbols <= w.syms;
        chunk <= w.chk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_word(w);
        if (w.typed_n >= 0)
        begin
            for (int i = 0; i < w.typed_n; i++)
                pending_symbols.push_back({w.typed_syms[8*i +: 8], 1'(i == w.typed_n - 1)});
        end
        else
        begin
            foreach (predicted[i])
                pending_symbols.push_back(predicted[i]);
        end
        words_sent++;
        case (w.kind)
            KIND_LOAD: n_loads++;
            KIND_CHUNK: n_chunks++;
            KIND_RESTART: n_restarts++;
            default: n_ignored++;
        endcase
    endtask

    initial
    begin
        stim_row_t   w;
        logic [63:0] r64;
        int          choices [$];
        int          counted;

        directed[0]  = '{KIND_LOAD,    16'h0000, 8'h00, 3'd1, 56'hA5, 8'h00, 0, 56'h0};
        directed[1]  = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h00, 1, 56'hA5};
        directed[2]  = '{KIND_LOAD,    16'h00FF, 8'hFF, 3'd7, 56'hFFFFFFFFFFFFFF, 8'h00,
                         0, 56'h0};
        directed[3]  = '{KIND_LOAD,    16'hFFFF, 8'h00, 3'd7, 56'h07060504030201, 8'hFF,
                         0, 56'h0};
        directed[4]  = '{KIND_LOAD,    16'hFF00, 8'h01, 3'd0, 56'hDEADBEEF00C0DE, 8'h00,
                         0, 56'h0};
        directed[5]  = '{KIND_LOAD,    16'h0080, 8'hFF, 3'd0, 56'h0, 8'h00, 0, 56'h0};
        directed[6]  = '{KIND_LOAD,    16'h0155, 8'h00, 3'd3, 56'hAABBCCDD332211, 8'h00,
                         0, 56'h0};
        directed[7]  = '{KIND_CHUNK,   16'hFFFF, 8'hFF, 3'd7, 56'h0, 8'hFF,
                         7, 56'hFFFFFFFFFFFFFF};
        directed[8]  = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'hFF,
                         7, 56'h07060504030201};
        directed[9]  = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h80, 0, 56'h0};
        directed[10] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h00, 0, 56'h0};
        directed[11] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h55, -1, 56'h0};
        directed[12] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h80, 0, 56'h0};
        directed[13] = '{KIND_RESTART, 16'hFFFF, 8'hFF, 3'd7, 56'hFFFFFFFFFFFFFF, 8'hFF,
                         0, 56'h0};
        directed[14] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h00, 1, 56'hA5};
        directed[15] = '{KIND_UNKNOWN, 16'h0000, 8'hFF, 3'd7, 56'h123456789ABCDE, 8'h00,
                         0, 56'h0};
        directed[16] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h00, 1, 56'hA5};
        directed[17] = '{KIND_LOAD,    16'h0000, 8'h01, 3'd2, 56'h3CC3, 8'h00, 0, 56'h0};
        directed[18] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h00, -1, 56'h0};
        directed[19] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h55, -1, 56'h0};
        directed[20] = '{KIND_LOAD,    16'h0001, 8'h00, 3'd5, 56'h0123456789ABCD, 8'h00,
                         0, 56'h0};
        directed[21] = '{KIND_CHUNK,   16'h0000, 8'h00, 3'd0, 56'h0, 8'h01, -1, 56'h0};

        rst_n <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_word(directed[i]);

        counted = 0;
        while (counted < RANDOM_WORDS)
        begin
            r64 = {$urandom, $urandom};
            w.syms = r64[SYMBOLS_W-1:0];
            w.addr = ADDR_FIELD_W'($urandom);
            w.next_tbl = TABLE_W'($urandom);
            w.count = COUNT_W'($urandom);
            w.chk = CHUNK_W'($urandom);
            w.typed_n = -1;
            w.typed_syms = '0;
            case ($urandom_range(0, 99)) inside
                [0:7]: w.kind = KIND_UNKNOWN;
                [8:15]: w.kind = KIND_RESTART;
                [16:44]:
                begin
                    w.kind = KIND_LOAD;
                    if ($urandom_range(0, 9) < 7)
                        w.addr = {HOT_TABLES[$urandom_range(0, 3)], w.chk};
                    if ($urandom_range(0, 4) != 0)
                        w.next_tbl = HOT_TABLES[$urandom_range(0, 3)];
                end
                default:
                begin
                    w.kind = KIND_CHUNK;
                    choices.delete();
                    for (int c = 0; c < (1 << JUMP_BITS); c++)
                        if (jump_entries.exists({table_sel, JUMP_BITS'(c)}))
                            choices.push_back(c);
                    if (choices.size() == 0)
                    begin
                        w.kind = KIND_LOAD;
                        w.addr = {table_sel, w.chk};
                    end
                    else
                        w.chk = CHUNK_W'(choices[$urandom_range(0, choices.size() - 1)]);
                end
            endcase
            counted++;
            send_word(w);
        end

        in_valid <= 1'b0;
        while (pending_symbols.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_symbols.size() != 0)
        begin
            $display("%0t: %0d symbols never arrived: expected %h last %b, actual none",
                     $time, pending_symbols.size(), pending_symbols[0].sym,
                     pending_symbols[0].last);
            mismatches++;
        end

        $display("Run covered %0d words: %0d loads, %0d chunks, %0d restarts, %0d ignored.",
                 words_sent, n_loads, n_chunks, n_restarts, n_ignored);
        $display("Checked %0d decoded symbols in %0d cycles, %0d mismatches.",
                 symbols_checked, cycle_count, mismatches);
        if (mismatches == 0)
            $display("multibit_huffman_jump_decoder_core verification clean");
        else
            $display("multibit_huffman_jump_decoder_core verification failed");
        $finish;
    end

endmodule
